// ===== hdl/saltst_pkg.sv =====
// Shared types and constants for the set-associative LRU tag store.
// Used by saltst_ctrl, saltst_dp and set_assoc_lru_tag_store_top.
package saltst_pkg;

	localparam int ADDR_W = 64;
	localparam int CNT_W  = 64;
	localparam int OUT_W  = 200;
	localparam int OUT_PAD = OUT_W - (2 + ADDR_W + 2 * CNT_W);

	// configuration register indexes and reset values
	localparam logic [1:0] CFG_WAYS = 2'd0;
	localparam logic [1:0] CFG_LINE = 2'd1;
	localparam logic [1:0] CFG_SETS = 2'd2;

	localparam logic [3:0] WAYS_RST = 4'd8;
	localparam logic [3:0] LINE_RST = 4'd6;
	localparam logic [2:0] SETS_RST = 3'd6;

	typedef enum logic [1:0] {
		ACT_PROBE    = 2'd0,
		ACT_INSERT   = 2'd1,
		ACT_INVAL    = 2'd2,
		ACT_CONTAINS = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic look;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic need_scan;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/set_assoc_lru_tag_store_top.sv =====
// Top level of the set-associative LRU tag store.
// Depends on saltst_pkg, saltst_ctrl, saltst_dp (and saltst_ram through it).
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: address; tuser: action
//  m_axis    out  m_axis_tvalid/tready   tdata: hit, evicted_valid, evicted_address,
//                                               access_total, miss_total
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Probe, invalidate and contains go through accept/RAM read, lookup and commit.
// Insert into a full set with nw > 1 adds an LRU scan, one stamp compare per cycle.
// After reset a sweep clears every set of the valid RAM before the first request.
// A request is accepted only in the idle state; the output register holds one result
// and commit waits while it is full and not being read.
module set_assoc_lru_tag_store_top
	import saltst_pkg::*;
#(
	parameter int MAX_SETS = 64,
	parameter int MAX_WAYS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [ADDR_W-1:0] s_axis_tdata,   // [63:0] address
	input  logic [1:0]        s_axis_tuser,   // [1:0] action
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [0] hit, [1] evicted_valid, [65:2] evicted_address,
	// [129:66] access_total, [193:130] miss_total, [199:194] zero
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	saltst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts(sts),
		.cmd(cmd)
	);

	saltst_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_tdata(s_axis_tdata),
		.in_tuser(s_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);

endmodule

// ===== hdl/saltst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module saltst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/saltst_ctrl.sv =====
// Sequencer for the tag store: clear sweep, lookup, LRU scan and commit.
// Depends on saltst_pkg.
module saltst_ctrl
	import saltst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_LOOK;
			ST_LOOK:  state_d = sts.need_scan ? ST_SCAN : ST_UPD;
			ST_SCAN:  if (sts.scan_last) state_d = ST_UPD;
			ST_UPD:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOOK:  cmd.look = 1'b1;
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_UPD:   cmd.commit = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	a_commit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free) else $error("commit with output slot busy");

	a_commit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> in_ready) else $error("not ready after commit");

endmodule

// ===== hdl/saltst_dp.sv =====
// Datapath: config registers, address split, set RAMs, hit/free/LRU selection,
// counters and output register. Depends on saltst_pkg and saltst_ram.
module saltst_dp
	import saltst_pkg::*;
#(
	parameter int MAX_SETS = 64,
	parameter int MAX_WAYS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [ADDR_W-1:0]  in_tdata,
	input  logic [1:0]         in_tuser,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   out_data
);

	localparam int WAW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NWW    = $clog2(MAX_WAYS + 1);
	localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SS_MAX = ((1 << $clog2(MAX_SETS)) > MAX_SETS) ?
		$clog2(MAX_SETS) - 1 : $clog2(MAX_SETS);
	localparam int ROW_W  = MAX_WAYS * ADDR_W;

	// config
	logic [3:0] wiu_q;
	logic [3:0] ls_q;
	logic [2:0] ss_q;
	logic [2:0] ss_eff;
	logic [NWW-1:0] nw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= WAYS_RST;
			ls_q  <= LINE_RST;
			ss_q  <= SETS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WAYS: wiu_q <= cfg_data;
				CFG_LINE: ls_q  <= cfg_data;
				CFG_SETS: ss_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(ss_q) > SS_MAX) begin
			ss_eff = 3'(SS_MAX);
		end else begin
			ss_eff = ss_q;
		end
		if (wiu_q == 4'd0) begin
			nw = NWW'(1);
		end else if (int'(wiu_q) > MAX_WAYS) begin
			nw = NWW'(MAX_WAYS);
		end else begin
			nw = NWW'(wiu_q);
		end
	end

	// address split
	logic [ADDR_W-1:0] line_in, set_mask, tag_in;
	logic [SET_AW-1:0] set_in;

	always_comb begin
		line_in  = in_tdata >> ls_q;
		set_mask = (ADDR_W'(1) << ss_eff) - ADDR_W'(1);
		set_in   = SET_AW'(line_in & set_mask);
		tag_in   = line_in >> ss_eff;
	end

	act_t              act_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [SET_AW-1:0] set_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_s1 <= act_t'(in_tuser);
			tag_s1 <= tag_in;
			set_s1 <= set_in;
		end
	end

	// set RAMs
	logic [ROW_W-1:0]    tag_rd, stamp_rd, tag_wr, stamp_wr;
	logic [MAX_WAYS-1:0] valid_rd, valid_wr, valid_wdata;
	logic                tag_we, stamp_we, valid_we;
	logic [SET_AW-1:0]   waddr, clr_q;

	saltst_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wr),
		.re(cmd.accept), .raddr(set_in), .rdata(tag_rd)
	);

	saltst_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_stamp_ram (
		.clk(clk), .we(stamp_we), .waddr(waddr), .wdata(stamp_wr),
		.re(cmd.accept), .raddr(set_in), .rdata(stamp_rd)
	);

	saltst_ram #(.WIDTH(MAX_WAYS), .DEPTH(MAX_SETS)) u_valid_ram (
		.clk(clk), .we(valid_we), .waddr(waddr), .wdata(valid_wdata),
		.re(cmd.accept), .raddr(set_in), .rdata(valid_rd)
	);

	// valid-bit clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + SET_AW'(1);
		end
	end

	// lookup: lowest matching way over all ways, lowest free way below nw
	logic           hit_any, free_any;
	logic [WAW-1:0] hit_way, free_way;

	always_comb begin
		hit_any  = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (valid_rd[w] && tag_rd[w*ADDR_W +: ADDR_W] == tag_s1) begin
				hit_any = 1'b1;
				hit_way = WAW'(w);
			end
			if (!valid_rd[w] && w < int'(nw)) begin
				free_any = 1'b1;
				free_way = WAW'(w);
			end
		end
	end

	logic           hit_q, free_q;
	logic [WAW-1:0] hit_way_q, free_way_q, best_q, idx_q;
	logic [ADDR_W-1:0] stamp_idx, stamp_best;

	assign stamp_idx  = stamp_rd[idx_q*ADDR_W +: ADDR_W];
	assign stamp_best = stamp_rd[best_q*ADDR_W +: ADDR_W];

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q      <= hit_any;
			hit_way_q  <= hit_way;
			free_q     <= free_any;
			free_way_q <= free_way;
			best_q     <= '0;
			idx_q      <= WAW'(1);
		end else if (cmd.scan_step) begin
			// strict less-than keeps the lowest way among equal stamps
			if (stamp_idx < stamp_best) begin
				best_q <= idx_q;
			end
			idx_q <= idx_q + WAW'(1);
		end
	end

	// update
	logic              is_probe, is_insert, is_inval, is_contains;
	logic [WAW-1:0]    pick, wsel;
	logic [ADDR_W-1:0] clk_q, acc_q, miss_q, clk_nxt, acc_nxt, miss_nxt;
	logic [ADDR_W-1:0] vtag, ev_base, ev_addr;
	logic              ev_valid, hit_out;

	always_comb begin
		is_probe    = (act_s1 == ACT_PROBE);
		is_insert   = (act_s1 == ACT_INSERT);
		is_inval    = (act_s1 == ACT_INVAL);
		is_contains = (act_s1 == ACT_CONTAINS);
		pick = free_q ? free_way_q : best_q;
		wsel = is_insert ? pick : hit_way_q;

		clk_nxt  = (is_probe || is_insert) ? clk_q + CNT_W'(1) : clk_q;
		acc_nxt  = is_probe ? acc_q + CNT_W'(1) : acc_q;
		miss_nxt = (is_probe && !hit_q) ? miss_q + CNT_W'(1) : miss_q;

		for (int w = 0; w < MAX_WAYS; w++) begin
			tag_wr[w*ADDR_W +: ADDR_W] = (WAW'(w) == pick) ? tag_s1 :
				tag_rd[w*ADDR_W +: ADDR_W];
			stamp_wr[w*ADDR_W +: ADDR_W] = (WAW'(w) == wsel) ? clk_nxt :
				stamp_rd[w*ADDR_W +: ADDR_W];
			valid_wr[w] = (WAW'(w) == wsel) ? is_insert : valid_rd[w];
		end

		vtag     = tag_rd[pick*ADDR_W +: ADDR_W];
		ev_base  = ((vtag << ss_eff) | ADDR_W'(set_s1)) << ls_q;
		ev_valid = is_insert && !free_q;
		ev_addr  = ev_valid ? ev_base : '0;
		hit_out  = (is_probe || is_contains) && hit_q;

		tag_we      = cmd.commit && is_insert;
		stamp_we    = cmd.commit && (is_insert || (is_probe && hit_q));
		valid_we    = cmd.clear_step || (cmd.commit && (is_insert || (is_inval && hit_q)));
		valid_wdata = cmd.clear_step ? '0 : valid_wr;
		waddr       = cmd.clear_step ? clr_q : set_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q  <= '0;
			acc_q  <= '0;
			miss_q <= '0;
		end else if (cmd.commit) begin
			clk_q  <= clk_nxt;
			acc_q  <= acc_nxt;
			miss_q <= miss_nxt;
		end
	end

	// output register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {{OUT_PAD{1'b0}}, miss_nxt, acc_nxt, ev_addr, ev_valid, hit_out};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts.clear_last = (clr_q == SET_AW'(MAX_SETS - 1));
		sts.need_scan  = is_insert && !free_any && (nw != NWW'(1));
		sts.scan_last  = (NWW'(idx_q) == nw - NWW'(1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (NWW'(idx_q) < nw)) else $error("LRU scan past ways in use");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_insert && !free_q) |-> (NWW'(best_q) < nw))
		else $error("victim way outside ways in use");

endmodule

// ===== tb/tb_set_assoc_lru_tag_store_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_lru_tag_store_top: directed table, then random phases.
// Needs saltst_pkg and the tag store RTL; a local LRU directory model predicts every result but typed rows.
module tb_set_assoc_lru_tag_store_top
	import saltst_pkg::*;
();

	localparam int MAX_SETS    = 64;
	localparam int MAX_WAYS    = 8;
	localparam int ENTRIES     = MAX_SETS * MAX_WAYS;
	localparam int SETTLE      = 16;    // cycles after the last result before a reg write
	localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
	localparam int HOLD_AT     = 250;   // request count that starts the long output hold
	localparam int HOLD_LEN    = 300;
	localparam int PHASE_REQS  = 60;
	localparam int N_PHASES    = 9;
	localparam logic [1:0] CFG_NONE = 2'd3;  // unused register index, writes are dropped

	typedef struct packed {
		logic        hit;
		logic        ev_valid;
		logic [63:0] ev_addr;
		logic [63:0] acc_total;
		logic [63:0] miss_total;
	} lookup_res_t;

	// one directed step: a register write or a request; typed rows carry their own answer
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  reg_idx;
		logic [3:0]  reg_val;
		act_t        act;
		logic [63:0] addr;
		logic        typed;
		logic        hit;
		logic [63:0] acc;
		logic [63:0] miss;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [ADDR_W-1:0] s_axis_tdata = '0;
	logic [1:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [3:0]        cfg_data = '0;

	// directory model state
	logic [63:0] tag_mem   [0:ENTRIES-1];
	logic [63:0] stamp_mem [0:ENTRIES-1];
	logic        valid_mem [0:ENTRIES-1];
	logic [63:0] use_stamp = '0;
	logic [63:0] acc_cnt = '0;
	logic [63:0] miss_cnt = '0;
	logic [3:0]  cfg_ways = WAYS_RST;
	logic [3:0]  cfg_line = LINE_RST;
	logic [2:0]  cfg_sets = SETS_RST;

	lookup_res_t pending_lookups[$];
	dir_row_t    dir_rows[$];
	logic [63:0] line_pool[$];

	int err_cnt = 0;
	int n_sent = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_evicts = 0;
	int n_hits = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	set_assoc_lru_tag_store_top #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_set_shift();
		int s;
		s = cfg_sets;
		while (s > 0 && (1 << s) > MAX_SETS)
			s--;
		return s;
	endfunction

	function automatic int eff_ways();
		if (cfg_ways == 4'd0)
			return 1;
		if (cfg_ways > MAX_WAYS)
			return MAX_WAYS;
		return cfg_ways;
	endfunction

	// lookups scan every way of the set, not just the ones in use
	function automatic int find_way(input int base, input logic [63:0] tag);
		for (int w = 0; w < MAX_WAYS; w++)
			if (valid_mem[base + w] && tag_mem[base + w] == tag)
				return w;
		return -1;
	endfunction

	function automatic lookup_res_t dir_lookup(input act_t act, input logic [63:0] addr);
		lookup_res_t res;
		int ss, nw, base, way, pick, i;
		logic [63:0] line, set_no, tag;
		res = '0;
		ss = eff_set_shift();
		nw = eff_ways();
		line = addr >> cfg_line;
		set_no = line & ((64'd1 << ss) - 64'd1);
		tag = line >> ss;
		base = int'(set_no) * MAX_WAYS;
		way = find_way(base, tag);
		case (act)
		ACT_PROBE: begin
			acc_cnt++;
			use_stamp++;
			if (way >= 0) begin
				stamp_mem[base + way] = use_stamp;
				res.hit = 1'b1;
			end else begin
				miss_cnt++;
			end
		end
		ACT_INSERT: begin
			use_stamp++;
			pick = -1;
			for (i = 0; i < nw; i++)
				if (!valid_mem[base + i] && pick < 0)
					pick = i;
			if (pick < 0) begin
				// full: oldest stamp goes, lowest way on a tie
				pick = 0;
				for (i = 1; i < nw; i++)
					if (stamp_mem[base + i] < stamp_mem[base + pick])
						pick = i;
				res.ev_valid = 1'b1;
				res.ev_addr = ((tag_mem[base + pick] << ss) | set_no) << cfg_line;
			end
			tag_mem[base + pick] = tag;
			stamp_mem[base + pick] = use_stamp;
			valid_mem[base + pick] = 1'b1;
		end
		ACT_INVAL: begin
			if (way >= 0)
				valid_mem[base + way] = 1'b0;
		end
		default: begin
			res.hit = (way >= 0);
		end
		endcase
		res.acc_total = acc_cnt;
		res.miss_total = miss_cnt;
		return res;
	endfunction

	task automatic queue_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic send_req(input act_t act, input logic [63:0] addr, input bit typed,
			input lookup_res_t typed_res);
		lookup_res_t res;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= addr;
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		res = dir_lookup(act, addr);
		if (res.hit)
			n_hits++;
		if (res.ev_valid)
			n_evicts++;
		pending_lookups.insert(pending_lookups.size(), typed ? typed_res : res);
		n_sent++;
		if (n_sent == HOLD_AT)
			hold_req = 1'b1;
	endtask

	// settle the block before touching a register
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_WAYS: cfg_ways = val;
		CFG_LINE: cfg_line = val;
		CFG_SETS: cfg_sets = val[2:0];
		default: ;
		endcase
		n_writes++;
		cfg_valid <= 1'b0;
	endtask

	// receiver: stretches of random stall density, plus one long hold
	initial begin
		int stretch, pct;
		forever begin
			stretch = $urandom_range(10, 80);
			case ($urandom_range(0, 3))
			0: pct = 0;
			1: pct = 30;
			2: pct = 60;
			default: pct = 85;
			endcase
			repeat (stretch) begin
				@(posedge clk);
				if (hold_req && !hold_done) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_LEN) @(posedge clk);
					hold_done = 1'b1;
				end
				m_axis_tready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		lookup_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_lookups.size() == 0) begin
				$error("result with no request outstanding");
				err_cnt++;
			end else begin
				want = pending_lookups.pop_front();
				if (m_axis_tdata[0] !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
					err_cnt++;
				end
				if (m_axis_tdata[1] !== want.ev_valid) begin
					$error("evicted_valid: expected %0d, got %0d", want.ev_valid,
						m_axis_tdata[1]);
					err_cnt++;
				end
				if (m_axis_tdata[65:2] !== want.ev_addr) begin
					$error("evicted_address: expected %h, got %h", want.ev_addr,
						m_axis_tdata[65:2]);
					err_cnt++;
				end
				if (m_axis_tdata[129:66] !== want.acc_total) begin
					$error("access_total: expected %0d, got %0d", want.acc_total,
						m_axis_tdata[129:66]);
					err_cnt++;
				end
				if (m_axis_tdata[193:130] !== want.miss_total) begin
					$error("miss_total: expected %0d, got %0d", want.miss_total,
						m_axis_tdata[193:130]);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [3:0] ph_ways [N_PHASES];
		logic [3:0] ph_line [N_PHASES];
		logic [2:0] ph_sets [N_PHASES];
		lookup_res_t want;
		logic [63:0] tag, line, addr, offs;
		int ss, n_sets, n_tags, pick;
		act_t act;

		ph_ways = '{4'd8, 4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd5, 4'd7, 4'd6};
		ph_line = '{4'd6, 4'd0, 4'd12, 4'd3, 4'd0, 4'd5, 4'd12, 4'd4, 4'd9};
		ph_sets = '{3'd6, 3'd0, 3'd6, 3'd1, 3'd6, 3'd2, 3'd0, 3'd3, 3'd5};

		for (int i = 0; i < ENTRIES; i++) begin
			tag_mem[i] = '0;
			stamp_mem[i] = '0;
			valid_mem[i] = 1'b0;
		end

		// fresh store, reset config: outcomes follow directly
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'd0, 1'b1, 1'b0, 64'd1, 64'd1});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_CONTAINS, '1, 1'b1, 1'b0, 64'd1, 64'd1});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'd0, 1'b1, 1'b0, 64'd1, 64'd1});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'h3f, 1'b1, 1'b1, 64'd2, 64'd1});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INVAL, 64'h20, 1'b1, 1'b0, 64'd2, 64'd1});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_CONTAINS, 64'd0, 1'b1, 1'b0, 64'd2, 64'd1});
		// zero ways behaves as one way: second insert evicts the first
		queue_row('{1'b1, CFG_WAYS, 4'd0, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h1000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h2000, 1'b0, 1'b0, 64'd0, 64'd0});
		// oversized way count saturates; duplicate insert lands in a second way
		queue_row('{1'b1, CFG_WAYS, 4'd15, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h2000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'h2000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INVAL, 64'h2000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_CONTAINS, 64'h2000, 1'b0, 1'b0, 64'd0,
			64'd0});
		// shrink to one way: the copy in way 1 stays visible to lookups
		queue_row('{1'b1, CFG_WAYS, 4'd1, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'h2000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h3000, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h4000, 1'b0, 1'b0, 64'd0, 64'd0});
		// too many sets clamps, byte lines, a dropped write to an unused index
		queue_row('{1'b1, CFG_SETS, 4'd7, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b1, CFG_LINE, 4'd0, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b1, CFG_NONE, 4'd9, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b1, CFG_WAYS, 4'd8, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, '1, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, '1, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'h8000_0000_0000_0000, 1'b0,
			1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_CONTAINS, 64'h8000_0000_0000_0000, 1'b0,
			1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'h7fff_ffff_ffff_ffff, 1'b0,
			1'b0, 64'd0, 64'd0});
		// 4096-byte lines, single set
		queue_row('{1'b1, CFG_LINE, 4'd12, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b1, CFG_SETS, 4'd0, ACT_PROBE, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, '1, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INSERT, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_PROBE, 64'hfff, 1'b0, 1'b0, 64'd0, 64'd0});
		queue_row('{1'b0, CFG_WAYS, 4'd0, ACT_INVAL, 64'hffff_ffff_ffff_f000, 1'b0,
			1'b0, 64'd0, 64'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				want = '{dir_rows[i].hit, 1'b0, 64'd0, dir_rows[i].acc, dir_rows[i].miss};
				send_req(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].typed, want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(CFG_WAYS, ph_ways[ph]);
			write_reg(CFG_LINE, ph_line[ph]);
			// top data bit is don't-care for the set count
			write_reg(CFG_SETS, {1'($urandom_range(0, 1)), ph_sets[ph]});

			// a few crowded sets, more tags than ways so inserts must evict
			ss = eff_set_shift();
			n_sets = (ss == 0) ? 1 : (((1 << ss) < 3) ? (1 << ss) : 3);
			line_pool.delete();
			for (int s = 0; s < n_sets; s++) begin
				line = $urandom_range(0, (1 << ss) - 1);
				n_tags = eff_ways() + $urandom_range(1, 4);
				for (int t = 0; t < n_tags; t++) begin
					tag = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
						: {$urandom, $urandom};
					line_pool.insert(line_pool.size(), (tag << ss) | line);
				end
			end

			repeat (PHASE_REQS) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					act = ACT_PROBE;
				else if (pick < 65)
					act = ACT_INSERT;
				else if (pick < 80)
					act = ACT_INVAL;
				else
					act = ACT_CONTAINS;
				offs = {$urandom, $urandom} & ((64'd1 << cfg_line) - 64'd1);
				if ($urandom_range(0, 99) < 8)
					addr = {$urandom, $urandom};
				else
					addr = (line_pool[$urandom_range(0, line_pool.size() - 1)] << cfg_line)
						| offs;
				send_req(act, addr, 1'b0, '0);
			end
		end

		drain();
		if (pending_lookups.size() != 0) begin
			$error("%0d results never arrived", pending_lookups.size());
			err_cnt++;
		end
		$display("Ran %0d requests over %0d register writes and %0d way/line/set settings.",
			n_sent, n_writes, N_PHASES);
		$display("Checked %0d results: %0d hits, %0d evictions, output held off for %0d cycles.",
			n_results, n_hits, n_evicts, HOLD_LEN);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/saltst_pkg.sv
hdl/saltst_ram.sv
hdl/saltst_ctrl.sv
hdl/saltst_dp.sv
hdl/set_assoc_lru_tag_store_top.sv
tb/tb_set_assoc_lru_tag_store_top.sv
